### hw/rtl/cas_pkg.sv
package cas_pkg;

	localparam int MaxResults = 3;
	localparam int CntW       = 2;
	localparam int QueueDepth = 2;
	localparam int QPtrW      = 1;

	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChSquote = 8'h27;
	localparam logic [7:0] ChDquote = 8'h22;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChN      = 8'h6E;
	localparam logic [7:0] ChT      = 8'h74;
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChBang   = 8'h21;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       new_argument;
		logic       line_done;
	} out_item_t;

	// results of one input byte, slot 0 goes out first
	typedef struct packed {
		out_item_t [MaxResults-1:0] res;
		logic [CntW-1:0]            cnt;
	} group_t;

	typedef enum logic [1:0] {
		DROP_NONE   = 2'd0,
		DROP_SINGLE = 2'd1,
		DROP_DOUBLE = 2'd2
	} drop_t;

	typedef struct packed {
		logic  single_quoted;
		logic  double_quoted;
		logic  between_arguments;
		logic  pending_backslash;
		drop_t after_quote_drop;
	} flags_t;

	localparam flags_t FlagsReset = '{
		single_quoted:     1'b0,
		double_quoted:     1'b0,
		between_arguments: 1'b1,
		pending_backslash: 1'b0,
		after_quote_drop:  DROP_NONE
	};

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == ChSpace) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

endpackage

### hw/rtl/cas_front.sv
module cas_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cas_pkg::in_item_t  in_item,
	input  cas_pkg::q_status_t q_status,
	output logic               push,
	output cas_pkg::group_t    push_group
);

	cas_pkg::flags_t flags_q;
	cas_pkg::flags_t f;
	cas_pkg::flags_t flags_nxt;
	cas_pkg::group_t g;
	logic [cas_pkg::CntW-1:0] n;
	logic [7:0] b;
	logic [7:0] esc_byte;
	logic       last;
	logic       esc_keep;
	logic       do_fresh;
	logic       do_place;
	logic       accept;

	always_comb begin
		f        = flags_q;
		g        = '0;
		n        = '0;
		b        = in_item.in_byte;
		last     = in_item.line_last;
		esc_keep = 1'b0;
		esc_byte = b;
		do_fresh = 1'b0;
		do_place = 1'b0;

		if (f.pending_backslash) begin
			f.pending_backslash = 1'b0;
			esc_keep = 1'b1;
			priority if (b == cas_pkg::ChN) begin
				esc_byte = cas_pkg::ChLf;
			end else if (b == cas_pkg::ChT) begin
				esc_byte = cas_pkg::ChTab;
			end else if (b == cas_pkg::ChDollar || b == cas_pkg::ChBang ||
				b == cas_pkg::ChBslash || b == cas_pkg::ChSpace) begin
				esc_byte = b;
			end else begin
				// not an escape: backslash is literal, byte handled on its own
				esc_byte = cas_pkg::ChBslash;
				do_fresh = 1'b1;
			end
		end else if (f.after_quote_drop == cas_pkg::DROP_SINGLE) begin
			f.after_quote_drop = cas_pkg::DROP_NONE;
			if (b == cas_pkg::ChDquote) begin
				f.double_quoted    = ~f.double_quoted;
				f.after_quote_drop = cas_pkg::DROP_DOUBLE;
			end else begin
				do_place = 1'b1;
			end
		end else if (f.after_quote_drop == cas_pkg::DROP_DOUBLE) begin
			f.after_quote_drop = cas_pkg::DROP_NONE;
			do_place = 1'b1;
		end else begin
			do_fresh = 1'b1;
		end

		if (esc_keep) begin
			g.res[n] = '{out_byte: esc_byte, byte_valid: 1'b1,
				new_argument: f.between_arguments, line_done: 1'b0};
			n = n + cas_pkg::CntW'(1);
			f.between_arguments = 1'b0;
		end

		if (do_fresh) begin
			priority if (b == cas_pkg::ChBslash && !f.single_quoted &&
				!f.double_quoted && !last) begin
				f.pending_backslash = 1'b1;
			end else if (b == cas_pkg::ChSquote) begin
				f.single_quoted    = ~f.single_quoted;
				f.after_quote_drop = cas_pkg::DROP_SINGLE;
			end else if (b == cas_pkg::ChDquote) begin
				f.double_quoted    = ~f.double_quoted;
				f.after_quote_drop = cas_pkg::DROP_DOUBLE;
			end else begin
				do_place = 1'b1;
			end
		end

		if (do_place) begin
			if (cas_pkg::is_ws(b) && !f.single_quoted && !f.double_quoted) begin
				f.between_arguments = 1'b1;
			end else begin
				g.res[n] = '{out_byte: b, byte_valid: 1'b1,
					new_argument: f.between_arguments, line_done: 1'b0};
				n = n + cas_pkg::CntW'(1);
				f.between_arguments = 1'b0;
			end
		end

		if (last) begin
			// quote dropped at line end while between arguments: empty argument
			if (f.after_quote_drop != cas_pkg::DROP_NONE && f.between_arguments) begin
				g.res[n] = '{out_byte: 8'h00, byte_valid: 1'b0,
					new_argument: 1'b1, line_done: 1'b0};
				n = n + cas_pkg::CntW'(1);
			end
			if (n == '0) begin
				g.res[n] = '0;
				n = n + cas_pkg::CntW'(1);
			end
			g.res[n - cas_pkg::CntW'(1)].line_done = 1'b1;
		end

		g.cnt     = n;
		flags_nxt = last ? cas_pkg::FlagsReset : f;
	end

	assign in_ready   = !q_status.full;
	assign accept     = in_valid && in_ready;
	assign push       = accept && (n != '0);
	assign push_group = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= cas_pkg::FlagsReset;
		end else if (accept) begin
			flags_q <= flags_nxt;
		end
	end

endmodule

### hw/rtl/cas_fifo.sv
module cas_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cas_pkg::group_t    push_group,
	input  logic               pop,
	output cas_pkg::group_t    head,
	output cas_pkg::q_status_t q_status
);

	cas_pkg::group_t mem_q [cas_pkg::QueueDepth];
	logic [cas_pkg::QPtrW-1:0] wr_ptr_q;
	logic [cas_pkg::QPtrW-1:0] rd_ptr_q;
	logic [cas_pkg::QPtrW:0]   count_q;
	logic do_push;
	logic do_pop;

	function automatic logic [cas_pkg::QPtrW-1:0] ptr_inc(
		input logic [cas_pkg::QPtrW-1:0] p
	);
		return (p == cas_pkg::QPtrW'(cas_pkg::QueueDepth - 1)) ? '0 :
			p + cas_pkg::QPtrW'(1);
	endfunction

	assign q_status.full  = (count_q == (cas_pkg::QPtrW + 1)'(cas_pkg::QueueDepth));
	assign q_status.empty = (count_q == '0);
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (cas_pkg::QPtrW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (cas_pkg::QPtrW + 1)'(1);
			end
		end
	end

endmodule

### hw/rtl/cas_back.sv
module cas_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cas_pkg::group_t    head,
	input  cas_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output cas_pkg::out_item_t out_item
);

	logic [cas_pkg::CntW-1:0] idx_q;
	logic                     out_valid_q;
	cas_pkg::out_item_t       out_item_q;
	logic load;
	logic take;
	logic group_end;

	assign load      = !out_valid_q || out_ready;
	assign take      = load && !q_status.empty;
	assign group_end = (idx_q == head.cnt - cas_pkg::CntW'(1));
	assign pop       = take && group_end;

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q <= head.res[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !q_status.empty;
			end
			if (take) begin
				idx_q <= group_end ? '0 : idx_q + cas_pkg::CntW'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### hw/rtl/command_line_argument_splitter.sv
// Command-line splitter: takes one line byte by byte (line_last on the final byte) and
// gives the kept argument bytes, each marked when it starts a new argument, with
// backslash escapes translated and quote bytes dropped; the last result of a line
// carries line_done and the quoting state then starts over. A byte is accepted every
// cycle while the queue is not full; it gives zero, one or two results, and the output
// register sends one result per cycle while out_ready is high. The classifier updates
// its flags in the cycle a byte is accepted and writes the byte's results as one group
// into a two-entry queue, which absorbs output stalls and lets input run on.
module command_line_argument_splitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cas_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cas_pkg::out_item_t out_item
);

	cas_pkg::q_status_t q_status;
	cas_pkg::group_t    push_group;
	cas_pkg::group_t    head;
	logic               push;
	logic               pop;

	cas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.q_status   (q_status),
		.push       (push),
		.push_group (push_group)
	);

	cas_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	cas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

### dv/split_checker.sv
module split_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  cas_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  cas_pkg::out_item_t out_item,
	output int                 mismatches,
	output int                 pending,
	output int                 results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// splitter flags as the predictor sees them
	logic           in_single;
	logic           in_double;
	logic           at_gap;
	logic           esc_wait;
	cas_pkg::drop_t last_drop;

	cas_pkg::out_item_t expected_chars[$];
	cas_pkg::out_item_t step_out[$];

	initial begin
		mismatches = 0;
		pending = 0;
		results_checked = 0;
	end

	task automatic clear_flags();
		in_single = 1'b0;
		in_double = 1'b0;
		at_gap    = 1'b1;
		esc_wait  = 1'b0;
		last_drop = cas_pkg::DROP_NONE;
	endtask

	function automatic logic blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	task automatic emit(input logic [7:0] c, input logic kept, input logic starts);
		cas_pkg::out_item_t r;
		r.out_byte = c;
		r.byte_valid = kept;
		r.new_argument = starts;
		r.line_done = 1'b0;
		step_out.push_back(r);
	endtask

	// unescaped blank outside quotes only separates; anything else is kept
	task automatic keep_char(input logic [7:0] c, input logic escaped);
		if (!escaped && blank(c) && !in_single && !in_double) begin
			at_gap = 1'b1;
		end else begin
			emit(c, 1'b1, at_gap);
			at_gap = 1'b0;
		end
	endtask

	task automatic plain_char(input logic [7:0] c, input logic last);
		if (c == cas_pkg::ChBslash && !in_single && !in_double && !last) begin
			esc_wait = 1'b1;
		end else if (c == cas_pkg::ChSquote) begin
			in_single = ~in_single;
			last_drop = cas_pkg::DROP_SINGLE;
		end else if (c == cas_pkg::ChDquote) begin
			in_double = ~in_double;
			last_drop = cas_pkg::DROP_DOUBLE;
		end else begin
			keep_char(c, 1'b0);
		end
	endtask

	task automatic split_byte(input logic [7:0] c, input logic last);
		cas_pkg::out_item_t r;
		step_out.delete();
		if (esc_wait) begin
			esc_wait = 1'b0;
			if (c == cas_pkg::ChN) begin
				keep_char(cas_pkg::ChLf, 1'b1);
			end else if (c == cas_pkg::ChT) begin
				keep_char(cas_pkg::ChTab, 1'b1);
			end else if (c == cas_pkg::ChDollar || c == cas_pkg::ChBang ||
				c == cas_pkg::ChBslash || c == cas_pkg::ChSpace) begin
				keep_char(c, 1'b1);
			end else begin
				keep_char(cas_pkg::ChBslash, 1'b1);
				plain_char(c, last);
			end
		end else if (last_drop == cas_pkg::DROP_SINGLE) begin
			// right after a dropped single quote only a double quote is special
			last_drop = cas_pkg::DROP_NONE;
			if (c == cas_pkg::ChDquote) begin
				in_double = ~in_double;
				last_drop = cas_pkg::DROP_DOUBLE;
			end else begin
				keep_char(c, 1'b0);
			end
		end else if (last_drop == cas_pkg::DROP_DOUBLE) begin
			last_drop = cas_pkg::DROP_NONE;
			keep_char(c, 1'b0);
		end else begin
			plain_char(c, last);
		end
		if (last) begin
			if (last_drop != cas_pkg::DROP_NONE && at_gap)
				emit(8'h00, 1'b0, 1'b1);
			if (step_out.size() == 0)
				emit(8'h00, 1'b0, 1'b0);
			r = step_out[step_out.size()-1];
			r.line_done = 1'b1;
			step_out[step_out.size()-1] = r;
			clear_flags();
		end
		foreach (step_out[i])
			expected_chars.push_back(step_out[i]);
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < 25)
			$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	initial clear_flags();

	always @(posedge clk) begin
		cas_pkg::out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				split_byte(in_item.in_byte, in_item.line_last);
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected result transfer, byte %h",
						out_item.out_byte));
				end else begin
					want = expected_chars.pop_front();
					results_checked++;
					if (out_item.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, want %h",
							out_item.out_byte, want.out_byte));
					if (out_item.byte_valid !== want.byte_valid)
						report_mismatch($sformatf("byte_valid %b, want %b",
							out_item.byte_valid, want.byte_valid));
					if (out_item.new_argument !== want.new_argument)
						report_mismatch($sformatf("new_argument %b, want %b",
							out_item.new_argument, want.new_argument));
					if (out_item.line_done !== want.line_done)
						report_mismatch($sformatf("line_done %b, want %b",
							out_item.line_done, want.line_done));
				end
			end
			pending = expected_chars.size();
		end
	end

endmodule

### dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 200000;
	localparam int HOLD  = 150;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	cas_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	cas_pkg::out_item_t out_item;

	int mismatches;
	int pending;
	int results_checked;

	int idle_pct;
	int stall_pct;
	int hold_req;
	int hold_cnt;
	int bytes_sent;
	int lines_sent;
	int cycles;

	command_line_argument_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	split_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_item        (out_item),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still due", cycles, pending);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off counted here on request
	initial begin
		out_ready = 1'b0;
		hold_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cnt != 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
			end else if (hold_req != 0) begin
				out_ready <= 1'b0;
				hold_cnt = HOLD - 1;
				hold_req = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic drive_char(input logic [7:0] c, input logic last);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{in_byte: c, line_last: last};
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		bytes_sent++;
		if (last)
			lines_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			drive_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 11))
			0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));
			3:       return cas_pkg::ChSpace;
			4:       return cas_pkg::ChSquote;
			5:       return cas_pkg::ChDquote;
			6, 7:    return cas_pkg::ChBslash;
			8: begin
				case ($urandom_range(0, 3))
					0:       return cas_pkg::ChN;
					1:       return cas_pkg::ChT;
					2:       return cas_pkg::ChDollar;
					default: return cas_pkg::ChBang;
				endcase
			end
			9:       return 8'($urandom_range(9, 13));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_line();
		int len;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			drive_char(pick_char(), i == len - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int sender_idle, input int recv_stall);
		int start;
		idle_pct = sender_idle;
		stall_pct = recv_stall;
		start = bytes_sent;
		while (bytes_sent - start < 10)
			send_random_line();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		bytes_sent = 0;
		lines_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes, quote toggling, empty argument, escapes, blank-only line
		drive_char(8'h00, 1'b0);
		drive_char(cas_pkg::ChSpace, 1'b0);
		drive_char(8'hFF, 1'b1);
		send_text("'\"x'");
		send_text("\"\"");
		send_text("\\n\\t\\ \\q\\");
		send_text("\t");
		send_text("a\"'\"\\");
		wait_drained();

		random_phase(0, 0);
		random_phase(81, 0);
		random_phase(0, 81);
		random_phase(15, 15);

		// long output hold-off while input keeps coming, so the queue backs up
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1;
		for (int i = 0; i < 4; i++)
			send_random_line();
		wait_drained();

		repeat (20) @(negedge clk);
		$display("Sent %0d bytes in %0d lines; %0d results checked, %0d mismatches",
			bytes_sent, lines_sent, results_checked, mismatches);
		$display("Covered quoting, escapes and line ends under sender gaps and output stalls");
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/cas_pkg.sv
hw/rtl/cas_front.sv
hw/rtl/cas_fifo.sv
hw/rtl/cas_back.sv
hw/rtl/command_line_argument_splitter.sv
dv/split_checker.sv
dv/tb.sv
